FILE: design/bpa_pkg.sv
// shared types, constants and codes for the bitmap page allocator
package bpa_pkg;

  // bitmap organisation
  localparam int unsigned WORD_BITS     = 64;
  localparam int unsigned BIT_W         = 6;
  localparam int unsigned MAX_PAGES_DEF = 1024;

  // field and register widths
  localparam int unsigned ADDR_W   = 48;
  localparam int unsigned PB_W     = 22;
  localparam int unsigned CNT_W    = 11;
  localparam int unsigned ABYTES_W = 32;
  localparam int unsigned PIDX_W   = 10;
  localparam int unsigned STAT_W   = 2;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 48;

  // derived datapath widths
  localparam int unsigned SCAN_W = CNT_W - BIT_W + 1;
  localparam int unsigned PROD_W = CNT_W + PB_W;
  localparam int unsigned DIVD_W = ABYTES_W;
  localparam int unsigned QUO_W  = CNT_W;

  // register reset values
  localparam logic [ADDR_W-1:0]   ARENA_BASE_RST  = '0;
  localparam logic [PB_W-1:0]     PAGE_BYTES_RST  = PB_W'(4096);
  localparam logic [CNT_W-1:0]    PAGE_COUNT_RST  = CNT_W'(1024);
  localparam logic [ABYTES_W-1:0] ARENA_BYTES_RST = ABYTES_W'(4194304);

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ARENA_BASE  = 2'd0,
    CFG_PAGE_BYTES  = 2'd1,
    CFG_PAGE_COUNT  = 2'd2,
    CFG_ARENA_BYTES = 2'd3
  } bpa_cfg_e;

  // request operations
  typedef enum logic {
    FUNC_ALLOC = 1'b0,
    FUNC_FREE  = 1'b1
  } bpa_func_e;

  // result status codes
  typedef enum logic [STAT_W-1:0] {
    STAT_DONE  = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_RANGE = 2'd2
  } bpa_status_e;

  // sequencer states
  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_MUL,
    S_ADD,
    S_CHECK,
    S_LIMIT,
    S_DIV,
    S_READ,
    S_WRITE,
    S_EMIT
  } bpa_state_e;

  // request payload
  typedef struct packed {
    logic              func;
    logic [ADDR_W-1:0] free_addr;
  } bpa_in_t;

  // result payload
  typedef struct packed {
    logic [ADDR_W-1:0] page_addr;
    logic [PIDX_W-1:0] page_index;
    logic [STAT_W-1:0] status;
  } bpa_out_t;

  // live configuration seen by the sequencer
  typedef struct packed {
    logic [ADDR_W-1:0]   arena_base;
    logic [PB_W-1:0]     page_bytes;
    logic [ABYTES_W-1:0] arena_bytes;
    logic [CNT_W-1:0]    eff_count;
  } bpa_cfg_t;

  // divider request and response
  typedef struct packed {
    logic              start;
    logic [DIVD_W-1:0] dividend;
    logic [PB_W-1:0]   divisor;
  } bpa_div_req_t;

  typedef struct packed {
    logic             done;
    logic [QUO_W-1:0] quotient;
  } bpa_div_rsp_t;

endpackage

FILE: design/bpa_ram.sv
// generic single-write, single-read memory with registered read data
module bpa_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/bpa_div.sv
// restoring divider, one quotient bit per cycle, for the page index of a free
module bpa_div import bpa_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  bpa_div_req_t req_i,
  output bpa_div_rsp_t rsp_o
);

  localparam int unsigned K_W = $clog2(QUO_W);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [K_W-1:0]    k_q, k_d;
  logic [DIVD_W-1:0] rem_q, rem_d;
  logic [PB_W-1:0]   dsr_q, dsr_d;
  logic [QUO_W-1:0]  quo_q, quo_d;
  logic [DIVD_W:0]   shifted;
  logic [DIVD_W+1:0] diff;

  // trial subtract of the divisor aligned to the current quotient bit
  always_comb begin
    shifted = (DIVD_W + 1)'(dsr_q) << k_q;
    diff    = {2'b00, rem_q} - {1'b0, shifted};
    busy_d  = busy_q;
    done_d  = 1'b0;
    k_d     = k_q;
    rem_d   = rem_q;
    dsr_d   = dsr_q;
    quo_d   = quo_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      k_d    = K_W'(QUO_W - 1);
      rem_d  = req_i.dividend;
      dsr_d  = req_i.divisor;
      quo_d  = '0;
    end else if (busy_q) begin
      if (!diff[DIVD_W+1]) begin
        rem_d        = diff[DIVD_W-1:0];
        quo_d[k_q]   = 1'b1;
      end
      if (k_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        k_d = k_q - 1'b1;
      end
    end
  end

  // control flops
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  // datapath flops
  always_ff @(posedge clk_i) begin
    k_q   <= k_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
    quo_q <= quo_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

FILE: design/bpa_ctrl.sv
// sequencer: bitmap memory, first-fit scan, free path and result staging
module bpa_ctrl import bpa_pkg::*; #(
  parameter int unsigned MAX_PAGES = MAX_PAGES_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  bpa_cfg_t cfg_i,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  bpa_in_t  in_data_i,
  output logic     res_valid_o,
  input  logic     res_take_i,
  output bpa_out_t res_data_o
);

  localparam int unsigned MAP_WORDS = (MAX_PAGES + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned WADDR_W   = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;

  bpa_state_e state_q, state_d;

  logic [WADDR_W-1:0]  clr_q, clr_d;
  logic [SCAN_W-1:0]   iw_q, iw_d;
  logic [SCAN_W-1:0]   cw_q, cw_d;
  logic                rv_q, rv_d;
  logic [ADDR_W-1:0]   op_addr_q, op_addr_d;
  logic [CNT_W-1:0]    idx_q, idx_d;
  logic [PROD_W-1:0]   prod_q, prod_d;
  logic                in_range_q, in_range_d;
  logic [DIVD_W-1:0]   offs_q, offs_d;
  logic [PROD_W-1:0]   lim_q, lim_d;
  bpa_out_t            res_q, res_d;

  // memory port signals
  logic                 mem_we, mem_re;
  logic [WADDR_W-1:0]   mem_waddr, mem_raddr;
  logic [WORD_BITS-1:0] mem_wdata, mem_rdata;

  // scan helpers
  logic                 issue_ok;
  logic [CNT_W:0]       rem_pages;
  logic [WORD_BITS-1:0] lim_mask;
  logic [WORD_BITS-1:0] avail;
  logic                 found;
  logic [BIT_W-1:0]     first_j;

  // free path helpers
  logic [ADDR_W:0]      end_sum;
  logic [WADDR_W-1:0]   free_word;
  logic [WORD_BITS-1:0] free_mask;

  bpa_div_req_t div_req;
  bpa_div_rsp_t div_rsp;

  bpa_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (MAP_WORDS)
  ) u_map_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  bpa_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // word-level scan: pages of the returned word that lie below the count and are free
  always_comb begin
    issue_ok  = {iw_q, {BIT_W{1'b0}}} < {1'b0, cfg_i.eff_count};
    rem_pages = {1'b0, cfg_i.eff_count} - {cw_q, {BIT_W{1'b0}}};
    if (rem_pages >= (CNT_W + 1)'(WORD_BITS)) begin
      lim_mask = '1;
    end else begin
      lim_mask = (WORD_BITS'(1) << rem_pages[BIT_W-1:0]) - WORD_BITS'(1);
    end
    avail   = ~mem_rdata & lim_mask;
    found   = |avail;
    first_j = '0;
    for (int j = WORD_BITS - 1; j >= 0; j--) begin
      if (avail[j]) begin
        first_j = BIT_W'(j);
      end
    end
  end

  // free path address decode
  always_comb begin
    end_sum   = {1'b0, cfg_i.arena_base} + (ADDR_W + 1)'(cfg_i.arena_bytes);
    free_word = WADDR_W'(idx_q >> BIT_W);
    free_mask = WORD_BITS'(1) << idx_q[BIT_W-1:0];
  end

  // next state, memory control and datapath updates
  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    iw_d        = iw_q;
    cw_d        = cw_q;
    rv_d        = rv_q;
    op_addr_d   = op_addr_q;
    idx_d       = idx_q;
    prod_d      = prod_q;
    in_range_d  = in_range_q;
    offs_d      = offs_q;
    lim_d       = lim_q;
    res_d       = res_q;
    mem_we      = 1'b0;
    mem_waddr   = '0;
    mem_wdata   = '0;
    mem_re      = 1'b0;
    mem_raddr   = '0;
    div_req     = '0;
    in_stall_o  = 1'b1;
    res_valid_o = 1'b0;

    case (state_q)
      // sweep zeros through the bitmap after reset
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        if (clr_q == WADDR_W'(MAP_WORDS - 1)) begin
          state_d = S_IDLE;
        end else begin
          clr_d = clr_q + 1'b1;
        end
      end

      // take one request
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          op_addr_d = in_data_i.free_addr;
          iw_d      = '0;
          rv_d      = 1'b0;
          if (in_data_i.func == FUNC_FREE) begin
            state_d = S_CHECK;
          end else begin
            state_d = S_SCAN;
          end
        end
      end

      // stream word reads, examine the previous word each cycle
      S_SCAN: begin
        if (issue_ok) begin
          mem_re    = 1'b1;
          mem_raddr = WADDR_W'(iw_q);
          iw_d      = iw_q + 1'b1;
          cw_d      = iw_q;
        end
        rv_d = issue_ok;
        if (rv_q && found) begin
          mem_we    = 1'b1;
          mem_waddr = WADDR_W'(cw_q);
          mem_wdata = mem_rdata | (WORD_BITS'(1) << first_j);
          idx_d     = CNT_W'({cw_q, first_j});
          state_d   = S_MUL;
        end else if (!issue_ok) begin
          res_d.page_addr  = '0;
          res_d.page_index = '0;
          res_d.status     = STAT_FULL;
          state_d          = S_EMIT;
        end
      end

      // page offset of the allocated page
      S_MUL: begin
        prod_d  = PROD_W'(idx_q) * PROD_W'(cfg_i.page_bytes);
        state_d = S_ADD;
      end

      S_ADD: begin
        res_d.page_addr  = cfg_i.arena_base + ADDR_W'(prod_q);
        res_d.page_index = PIDX_W'(idx_q);
        res_d.status     = STAT_DONE;
        state_d          = S_EMIT;
      end

      // containment check and page limit of the free address
      S_CHECK: begin
        in_range_d = (op_addr_q >= cfg_i.arena_base) && ({1'b0, op_addr_q} < end_sum);
        offs_d     = DIVD_W'(op_addr_q - cfg_i.arena_base);
        lim_d      = PROD_W'(cfg_i.eff_count) * PROD_W'(cfg_i.page_bytes);
        state_d    = S_LIMIT;
      end

      S_LIMIT: begin
        if (!in_range_q || (cfg_i.page_bytes == '0) || (PROD_W'(offs_q) >= lim_q)) begin
          res_d.page_addr  = '0;
          res_d.page_index = '0;
          res_d.status     = STAT_RANGE;
          state_d          = S_EMIT;
        end else begin
          div_req.start    = 1'b1;
          div_req.dividend = offs_q;
          div_req.divisor  = cfg_i.page_bytes;
          state_d          = S_DIV;
        end
      end

      S_DIV: begin
        if (div_rsp.done) begin
          idx_d   = div_rsp.quotient;
          state_d = S_READ;
        end
      end

      // read-modify-write of the word that holds the freed page
      S_READ: begin
        mem_re    = 1'b1;
        mem_raddr = free_word;
        state_d   = S_WRITE;
      end

      S_WRITE: begin
        mem_we           = 1'b1;
        mem_waddr        = free_word;
        mem_wdata        = mem_rdata & ~free_mask;
        res_d.page_addr  = '0;
        res_d.page_index = PIDX_W'(idx_q);
        res_d.status     = STAT_DONE;
        state_d          = S_EMIT;
      end

      // hand the result to the output register
      S_EMIT: begin
        res_valid_o = 1'b1;
        if (res_take_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control flops
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      rv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      rv_q    <= rv_d;
    end
  end

  // datapath flops
  always_ff @(posedge clk_i) begin
    iw_q       <= iw_d;
    cw_q       <= cw_d;
    op_addr_q  <= op_addr_d;
    idx_q      <= idx_d;
    prod_q     <= prod_d;
    in_range_q <= in_range_d;
    offs_q     <= offs_d;
    lim_q      <= lim_d;
    res_q      <= res_d;
  end

  assign res_data_o = res_q;

endmodule

FILE: design/bitmap_page_allocator_unit.sv
// Page allocator for one arena, one bitmap bit per page, first fit. An allocate
// scans the bitmap memory one 64-bit word per cycle with reads streamed back to
// back. A free checks the address against the arena, divides the offset by the
// page size in a restoring divider (one quotient bit per cycle, 11 bits) and
// clears the bit with a read-modify-write. One request is in flight at a time;
// the next is taken while the previous result still waits in the output
// register. After reset the bitmap memory is cleared word by word, during
// which no request is taken; configuration writes are taken at any time and
// must only be issued while the block is idle.
module bitmap_page_allocator_unit import bpa_pkg::*; #(
  parameter int unsigned MAX_PAGES = MAX_PAGES_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  bpa_in_t               in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output bpa_out_t              out_data_o
);

  logic [ADDR_W-1:0]   arena_base_q;
  logic [PB_W-1:0]     page_bytes_q;
  logic [CNT_W-1:0]    page_count_q;
  logic [ABYTES_W-1:0] arena_bytes_q;

  bpa_cfg_t cfg;
  logic     res_valid, res_take;
  bpa_out_t res_data;
  logic     out_valid_q, out_valid_d;
  bpa_out_t out_data_q;

  assign cfg_ready_o = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      arena_base_q  <= ARENA_BASE_RST;
      page_bytes_q  <= PAGE_BYTES_RST;
      page_count_q  <= PAGE_COUNT_RST;
      arena_bytes_q <= ARENA_BYTES_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (bpa_cfg_e'(cfg_index_i))
        CFG_ARENA_BASE:  arena_base_q  <= ADDR_W'(cfg_data_i);
        CFG_PAGE_BYTES:  page_bytes_q  <= PB_W'(cfg_data_i);
        CFG_PAGE_COUNT:  page_count_q  <= CNT_W'(cfg_data_i);
        CFG_ARENA_BYTES: arena_bytes_q <= ABYTES_W'(cfg_data_i);
        default: begin
        end
      endcase
    end
  end

  // page count saturated at the bitmap capacity
  always_comb begin
    cfg.arena_base  = arena_base_q;
    cfg.page_bytes  = page_bytes_q;
    cfg.arena_bytes = arena_bytes_q;
    if (32'(page_count_q) > MAX_PAGES) begin
      cfg.eff_count = CNT_W'(MAX_PAGES);
    end else begin
      cfg.eff_count = page_count_q;
    end
  end

  bpa_ctrl #(
    .MAX_PAGES (MAX_PAGES)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .res_valid_o (res_valid),
    .res_take_i  (res_take),
    .res_data_o  (res_data)
  );

  // output register, loaded when empty or when its transfer completes
  assign res_take = res_valid && (!out_valid_q || !out_stall_i);

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_take) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take) begin
      out_data_q <= res_data;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

FILE: design/bpa_checker.sv
// port-level checks for the page allocator, bound to the top level
module bpa_checker import bpa_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_stall_o,
  input logic     out_valid_o,
  input logic     out_stall_i,
  input bpa_out_t out_data_o
);

  // a stalled result holds until its transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // one request at a time: busy right after a request transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request taken while another is in flight");

  // a failed request reports no page
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status == STAT_RANGE || out_data_o.status == STAT_FULL)
    |-> out_data_o.page_addr == '0 && out_data_o.page_index == '0)
    else $error("failed request carries a page");

endmodule

bind bitmap_page_allocator_unit bpa_checker u_bpa_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

FILE: dv/tb_bitmap_page_allocator_unit.sv
// testbench for the bitmap page allocator: directed and random requests checked against a predictor
module tb_bitmap_page_allocator_unit;
  import bpa_pkg::*;

  logic                  clk_i;
  logic                  rst_ni      = 1'b0;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_stall_o;
  bpa_in_t               in_data_i   = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  bpa_out_t              out_data_o;

  // shadow of the configuration registers and the page bitmap
  logic [ADDR_W-1:0]        sh_arena_base  = ARENA_BASE_RST;
  logic [PB_W-1:0]          sh_page_bytes  = PAGE_BYTES_RST;
  logic [CNT_W-1:0]         sh_page_count  = PAGE_COUNT_RST;
  logic [ABYTES_W-1:0]      sh_arena_bytes = ARENA_BYTES_RST;
  logic [MAX_PAGES_DEF-1:0] page_used      = '0;

  bpa_in_t     requests_pending[$];
  bpa_out_t    results_due[$];
  logic        in_fire = 1'b0;
  int unsigned in_gap = 0, in_calm = 0, out_hold = 0, out_calm = 0;
  int unsigned mismatches = 0;

  bitmap_page_allocator_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // expected result of one request, updating the shadow bitmap
  function automatic bpa_out_t predict_page_result(bpa_in_t req);
    bpa_out_t          res;
    logic [63:0]       eff, idx;
    logic [ADDR_W:0]   arena_end;
    logic [ADDR_W-1:0] offset;
    bit                hit;
    int                i;
    res = '0;
    eff = (sh_page_count > MAX_PAGES_DEF) ? 64'(MAX_PAGES_DEF) : 64'(sh_page_count);
    if (req.func == FUNC_ALLOC) begin
      // first fit over the pages in use
      res.status = STAT_FULL;
      hit = 1'b0;
      for (i = 0; i < MAX_PAGES_DEF; i++) begin
        if (!hit && i < eff && !page_used[i]) begin
          hit = 1'b1;
          page_used[i] = 1'b1;
          res.page_addr  = ADDR_W'(64'(sh_arena_base) + 64'(i) * 64'(sh_page_bytes));
          res.page_index = PIDX_W'(i);
          res.status     = STAT_DONE;
        end
      end
    end else begin
      // exact containment check, then page index by division
      arena_end  = (ADDR_W+1)'(sh_arena_base) + (ADDR_W+1)'(sh_arena_bytes);
      res.status = STAT_RANGE;
      if (req.free_addr >= sh_arena_base && (ADDR_W+1)'(req.free_addr) < arena_end &&
          sh_page_bytes != 0) begin
        offset = req.free_addr - sh_arena_base;
        idx    = 64'(offset) / 64'(sh_page_bytes);
        if (idx < eff) begin
          page_used[idx] = 1'b0;
          res.page_index = PIDX_W'(idx);
          res.status     = STAT_DONE;
        end
      end
    end
    return res;
  endfunction

  // idle length: mostly none or short, now and then long
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  // random request, frees mostly aimed at pages of the arena
  function automatic bpa_in_t make_request(int unsigned alloc_pct);
    bpa_in_t     req;
    logic [63:0] eff, k, off;
    req.free_addr = ADDR_W'({$urandom, $urandom});
    if ($urandom_range(0, 99) < alloc_pct) begin
      req.func = FUNC_ALLOC;
      return req;
    end
    req.func = FUNC_FREE;
    eff = (sh_page_count > MAX_PAGES_DEF) ? 64'(MAX_PAGES_DEF) : 64'(sh_page_count);
    if ($urandom_range(0, 9) < 8) begin
      if ($urandom_range(0, 1) == 0 && eff > 48) k = $urandom_range(0, 48);
      else k = $urandom_range(0, eff);
      off = (sh_page_bytes == 0) ? 64'd0 : 64'($urandom_range(0, sh_page_bytes - 1));
      req.free_addr = ADDR_W'(64'(sh_arena_base) + k * 64'(sh_page_bytes) + off);
    end else begin
      case ($urandom_range(0, 3))
        0: ;
        1: req.free_addr = sh_arena_base - 1'b1;
        2: req.free_addr = ADDR_W'(64'(sh_arena_base) + 64'(sh_arena_bytes));
        default: req.free_addr = ADDR_W'(64'(sh_arena_base) + 64'(sh_arena_bytes) - 1);
      endcase
    end
    return req;
  endfunction

  task automatic push_req(input bpa_func_e func, input logic [ADDR_W-1:0] addr);
    bpa_in_t req;
    req.func      = func;
    req.free_addr = addr;
    requests_pending.push_back(req);
  endtask

  // register write transfer, shadow updated on acceptance
  task automatic set_reg(input bpa_cfg_e idx, input logic [CFG_DATA_W-1:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_ARENA_BASE:  sh_arena_base  = value[ADDR_W-1:0];
      CFG_PAGE_BYTES:  sh_page_bytes  = value[PB_W-1:0];
      CFG_PAGE_COUNT:  sh_page_count  = value[CNT_W-1:0];
      CFG_ARENA_BYTES: sh_arena_bytes = value[ABYTES_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(posedge clk_i);
    while (requests_pending.size() != 0 || in_valid_i || results_due.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic randomise_config();
    logic [ADDR_W-1:0] base;
    logic [PB_W-1:0]   pb;
    logic [CNT_W-1:0]  cnt;
    logic [63:0]       eff, span;
    case ($urandom_range(0, 7))
      0: base = '0;
      1: base = '1;
      2: base = ADDR_W'(48'hFFFF_FFFF_FFFF - $urandom_range(0, 1 << 20));
      default: base = ADDR_W'({$urandom, $urandom});
    endcase
    case ($urandom_range(0, 11))
      0: pb = '0;
      1: pb = '1;
      2: pb = PB_W'(8);
      3, 4, 5: pb = PB_W'(1) << $urandom_range(3, 21);
      default: pb = PB_W'($urandom_range(1, 5000));
    endcase
    case ($urandom_range(0, 11))
      0: cnt = '0;
      1: cnt = CNT_W'(1);
      2: cnt = CNT_W'(64);
      3: cnt = CNT_W'(65);
      4: cnt = CNT_W'(1024);
      5: cnt = '1;
      6: cnt = CNT_W'($urandom_range(1025, 2046));
      7: cnt = CNT_W'($urandom_range(100, 400));
      default: cnt = CNT_W'($urandom_range(2, 40));
    endcase
    // arena size mostly just covers the pages in use
    eff  = (cnt > MAX_PAGES_DEF) ? 64'(MAX_PAGES_DEF) : 64'(cnt);
    span = eff * 64'(pb) + 64'($urandom_range(0, pb));
    case ($urandom_range(0, 11))
      0: span = 64'd8;
      1: span = 64'hFFFF_FFFF;
      2: span = 64'($urandom);
      3: span = 64'd0;
      default: ;
    endcase
    if (span > 64'hFFFF_FFFF) span = 64'hFFFF_FFFF;
    set_reg(CFG_ARENA_BASE, base);
    set_reg(CFG_PAGE_BYTES, CFG_DATA_W'(pb));
    set_reg(CFG_PAGE_COUNT, CFG_DATA_W'(cnt));
    set_reg(CFG_ARENA_BYTES, CFG_DATA_W'(span));
  endtask

  // request side: acceptance and prediction
  always @(posedge clk_i) begin
    in_fire <= rst_ni && in_valid_i && !in_stall_o;
    if (rst_ni && in_valid_i && !in_stall_o)
      results_due.push_back(predict_page_result(in_data_i));
  end

  // request driver, a stalled request is held unchanged
  always @(negedge clk_i) begin
    if (rst_ni && !(in_valid_i && !in_fire)) begin
      if (in_gap > 0) begin
        in_valid_i <= 1'b0;
        in_gap--;
      end else if (requests_pending.size() != 0) begin
        in_valid_i <= 1'b1;
        in_data_i  <= requests_pending.pop_front();
        if (in_calm > 0) begin
          in_calm--;
        end else begin
          in_gap = idle_len();
          if ($urandom_range(0, 39) == 0) in_calm = $urandom_range(20, 60);
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // result side stall pattern
  always @(negedge clk_i) begin
    if (out_hold > 0) begin
      out_stall_i <= 1'b1;
      out_hold--;
    end else begin
      out_stall_i <= 1'b0;
      if (out_calm > 0) begin
        out_calm--;
      end else begin
        out_hold = idle_len();
        if ($urandom_range(0, 39) == 0) out_calm = $urandom_range(20, 60);
      end
    end
  end

  // result check against the oldest expectation
  always @(posedge clk_i) begin : result_check
    bpa_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (results_due.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected result: addr %h index %0d status %0d",
                   out_data_o.page_addr, out_data_o.page_index, out_data_o.status);
        mismatches++;
      end else begin
        want = results_due.pop_front();
        if (out_data_o !== want) begin
          if (mismatches < 10)
            $display("mismatch: addr %h/%h index %0d/%0d status %0d/%0d (expected/actual)",
                     want.page_addr, out_data_o.page_addr, want.page_index,
                     out_data_o.page_index, want.status, out_data_o.status);
          mismatches++;
        end
      end
    end
  end

  // stimulus: directed corners, then random phases under changing settings
  initial begin : stimulus
    int unsigned pct;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: allocate, double free, out of range frees
    push_req(FUNC_ALLOC, '0);
    push_req(FUNC_ALLOC, '1);
    push_req(FUNC_ALLOC, ADDR_W'({$urandom, $urandom}));
    push_req(FUNC_FREE, '0);
    push_req(FUNC_FREE, '0);
    push_req(FUNC_FREE, ADDR_W'(2 * 4096 + 5));
    push_req(FUNC_FREE, '1);
    push_req(FUNC_FREE, ADDR_W'(4194304));
    push_req(FUNC_FREE, ADDR_W'(4194303));
    push_req(FUNC_ALLOC, '0);
    wait_drained();

    // arena at the top of the address space: frees at wrapped addresses
    set_reg(CFG_ARENA_BASE, 48'hFFFF_FFFF_FFF0);
    set_reg(CFG_PAGE_BYTES, 48'd8);
    set_reg(CFG_PAGE_COUNT, 48'd3);
    set_reg(CFG_ARENA_BYTES, 48'd24);
    push_req(FUNC_ALLOC, '0);
    push_req(FUNC_ALLOC, '0);
    push_req(FUNC_FREE, 48'hFFFF_FFFF_FFF8);
    push_req(FUNC_FREE, 48'hFFFF_FFFF_FFFF + 48'd8);
    push_req(FUNC_FREE, 48'hFFFF_FFFF_FFF0 + 48'd24);
    push_req(FUNC_FREE, 48'hFFFF_FFFF_FFEF);
    push_req(FUNC_ALLOC, '0);
    wait_drained();

    // no pages at all
    set_reg(CFG_PAGE_COUNT, '0);
    push_req(FUNC_ALLOC, '0);
    push_req(FUNC_FREE, 48'hFFFF_FFFF_FFF0);
    wait_drained();

    // zero page size
    set_reg(CFG_PAGE_COUNT, 48'd4);
    set_reg(CFG_PAGE_BYTES, '0);
    push_req(FUNC_ALLOC, '0);
    push_req(FUNC_FREE, 48'hFFFF_FFFF_FFF0);
    wait_drained();

    // largest page, count above the maximum, widest arena
    set_reg(CFG_ARENA_BASE, '0);
    set_reg(CFG_PAGE_BYTES, CFG_DATA_W'(22'h3F_FFFF));
    set_reg(CFG_PAGE_COUNT, CFG_DATA_W'(11'h7FF));
    set_reg(CFG_ARENA_BYTES, CFG_DATA_W'(32'hFFFF_FFFF));
    push_req(FUNC_ALLOC, '0);
    push_req(FUNC_FREE, 48'hFFFF_FFFE);
    push_req(FUNC_FREE, ADDR_W'(64'h3F_FFFF * 1023));
    wait_drained();

    // random phases
    for (int p = 0; p < 8; p++) begin
      randomise_config();
      pct = $urandom_range(35, 90);
      for (int n = 0; n < 80; n++) requests_pending.push_back(make_request(pct));
      wait_drained();
    end

    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && results_due.size() == 0) begin
      $display("tb_bitmap_page_allocator_unit: PASS");
    end else begin
      $display("tb_bitmap_page_allocator_unit: FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("tb_bitmap_page_allocator_unit: FAIL");
    $finish;
  end

endmodule
